// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define QPT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define QPT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/qpt_pkg.sv =====
// ----------------------------------------------------------------------------
// qpt_pkg
// Shared types and constants of the qubit placement table.
// ----------------------------------------------------------------------------
`default_nettype none

package qpt_pkg;

  localparam int unsigned QubitW = 10;
  localparam int unsigned SideW  = 6;
  localparam int unsigned CountW = 2 * SideW;  // holds side squared
  localparam int unsigned CellW  = 5;
  localparam int unsigned AreaW  = 11;

  localparam logic [SideW-1:0] SideReset = 6'd32;
  localparam logic [AreaW-1:0] AreaMax   = 11'd2047;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_SWAP    = 3'd1,
    OP_POS     = 3'd2,
    OP_AREA    = 3'd3,
    OP_OVERLAP = 3'd4
  } op_e;

  // One of the four qubit operands of a request
  typedef logic [1:0] slot_t;

  typedef struct packed {
    logic  load_item;
    logic  clr_step;
    logic  rd_en;
    slot_t rd_sel;
    logic  wr_en;
    slot_t wr_sel;
    logic  wr_from_phys;
    slot_t wr_phys_sel;
    logic  div_init;
    logic  div_step;
    logic  div_store;
    slot_t div_sel;
    logic  res_load;
    logic  res_err;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic idx_bad;
    logic phys_bad;
    logic clr_last;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/qpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// qpt_ctrl
// Sequencer: table clear after reset, index and cell checks, table reads
// and writes, coordinate divisions and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module qpt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire qpt_pkg::status_t status_i,
  output qpt_pkg::cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_PCHECK,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_STORE,
    ST_WRITE,
    ST_RESULT
  } state_e;

  state_e         state_q, state_d;
  qpt_pkg::slot_t slot_q, slot_d;
  logic           err_q, err_d;
  logic           out_valid_q, out_valid_d;
  logic           last_slot;
  logic           out_free;
  qpt_pkg::cmd_t  cmd;

  // Highest operand slot touched by each operation
  function automatic qpt_pkg::slot_t slot_last(input qpt_pkg::op_e op);
    qpt_pkg::slot_t s;
    unique case (op)
      qpt_pkg::OP_SWAP,
      qpt_pkg::OP_AREA:    s = 2'd1;
      qpt_pkg::OP_OVERLAP: s = 2'd3;
      default:             s = 2'd0;
    endcase
    return s;
  endfunction

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    cmd         = '0;
    last_slot   = (slot_q == slot_last(status_i.op));
    out_free    = !out_valid_q || !out_stall_i;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_item = 1'b1;
          slot_d        = '0;
          err_d         = 1'b0;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        slot_d = '0;
        priority if (status_i.idx_bad) begin
          err_d   = 1'b1;
          state_d = ST_RESULT;
        end else if (status_i.op == qpt_pkg::OP_LOAD) begin
          state_d = ST_WRITE;
        end else if (status_i.op == qpt_pkg::OP_SWAP || status_i.op == qpt_pkg::OP_POS ||
                     status_i.op == qpt_pkg::OP_AREA ||
                     status_i.op == qpt_pkg::OP_OVERLAP) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = slot_q;
        if (last_slot) begin
          slot_d  = '0;
          state_d = (status_i.op == qpt_pkg::OP_SWAP) ? ST_WRITE : ST_PCHECK;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
      ST_PCHECK: begin
        // a stored cell index may be stale after the side shrank
        if (status_i.phys_bad) begin
          err_d   = 1'b1;
          state_d = ST_RESULT;
        end else begin
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cmd.div_sel  = slot_q;
        state_d      = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DIV_STORE;
        end
      end
      ST_DIV_STORE: begin
        cmd.div_store = 1'b1;
        cmd.div_sel   = slot_q;
        if (last_slot) begin
          slot_d  = '0;
          state_d = ST_RESULT;
        end else begin
          slot_d  = slot_q + 2'd1;
          state_d = ST_DIV_INIT;
        end
      end
      ST_WRITE: begin
        // swap writes each entry with the cell read for the other one
        cmd.wr_en        = 1'b1;
        cmd.wr_sel       = slot_q;
        cmd.wr_from_phys = (status_i.op == qpt_pkg::OP_SWAP);
        cmd.wr_phys_sel  = {1'b0, ~slot_q[0]};
        if (last_slot) begin
          slot_d  = '0;
          state_d = ST_RESULT;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_err  = err_q;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      slot_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

// ===== rtl/qpt_dp.sv =====
// ----------------------------------------------------------------------------
// qpt_dp
// Datapath: placement memory, operand and range checks, shared restoring
// divider for cell coordinates, area and overlap logic, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qpt_dp #(
  parameter int unsigned MAX_SIDE = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire qpt_pkg::cmd_t                cmd_i,
  output qpt_pkg::status_t                  status_o,
  input  wire logic [qpt_pkg::SideW-1:0]    side_length_i,
  input  wire logic [2:0]                   op_i,
  input  wire logic [qpt_pkg::QubitW-1:0]   qubit_a_i,
  input  wire logic [qpt_pkg::QubitW-1:0]   qubit_b_i,
  input  wire logic [qpt_pkg::QubitW-1:0]   qubit_c_i,
  input  wire logic [qpt_pkg::QubitW-1:0]   qubit_d_i,
  input  wire logic [qpt_pkg::QubitW-1:0]   entry_value_i,
  output logic [qpt_pkg::CellW-1:0]         cell_x_o,
  output logic [qpt_pkg::CellW-1:0]         cell_y_o,
  output logic [qpt_pkg::AreaW-1:0]         box_area_o,
  output logic                              boxes_overlap_o,
  output logic                              index_error_o
);

  localparam int unsigned Depth = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned QW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned DSW   = qpt_pkg::SideW + QW;
  localparam int unsigned RW    = (AW > DSW) ? AW : DSW;
  localparam int unsigned CNTW  = (QW > 1) ? $clog2(QW) : 1;
  localparam int unsigned EW    = QW + 1;
  localparam int unsigned PW    = 2 * EW;
  localparam int unsigned ACW   = (PW > qpt_pkg::AreaW) ? PW : qpt_pkg::AreaW;

  // request operands
  qpt_pkg::op_e                  op_q;
  logic [qpt_pkg::QubitW-1:0]    qubit_q [4];
  logic [qpt_pkg::QubitW-1:0]    val_q;
  logic [qpt_pkg::SideW-1:0]     side_q;
  logic [qpt_pkg::CountW-1:0]    n_q;

  logic [qpt_pkg::SideW-1:0]     side_eff;
  logic [qpt_pkg::CountW-1:0]    n_d;

  logic [AW-1:0]                 mem [Depth];
  logic [AW-1:0]                 phys_q [4];
  logic [AW-1:0]                 clr_cnt_q;
  logic                          clr_last;
  logic [AW-1:0]                 rd_addr, wr_addr, wr_data;

  logic [RW-1:0]                 rem_q, dsr_q;
  logic [QW-1:0]                 quo_q;
  logic [CNTW-1:0]               dcnt_q;
  logic                          rem_ge;
  logic [QW-1:0]                 x_q [4];
  logic [QW-1:0]                 y_q [4];

  logic                          q_bad [4];
  logic                          val_bad;
  logic                          p_bad [4];
  logic                          idx_bad, phys_bad;

  logic [EW-1:0]                 lo_x1, hi_x1, lo_x2, hi_x2;
  logic [EW-1:0]                 lo_y1, hi_y1, lo_y2, hi_y2;
  logic [EW-1:0]                 dx, dy;
  logic [PW-1:0]                 prod;
  logic [qpt_pkg::AreaW-1:0]     area_d;
  logic                          ovl_d;

  logic [qpt_pkg::CellW-1:0]     cell_x_d, cell_y_d;
  logic [qpt_pkg::AreaW-1:0]     box_area_d;
  logic                          overlap_d;

  function automatic logic [QW-1:0] min2(input logic [QW-1:0] a, input logic [QW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [QW-1:0] max2(input logic [QW-1:0] a, input logic [QW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // side 0 acts as 1, oversize acts as the grid limit
  always_comb begin
    priority if (side_length_i == '0) begin
      side_eff = qpt_pkg::SideW'(1);
    end else if ({1'b0, side_length_i} > (qpt_pkg::SideW + 1)'(MAX_SIDE)) begin
      side_eff = qpt_pkg::SideW'(MAX_SIDE);
    end else begin
      side_eff = side_length_i;
    end
  end

  assign n_d = qpt_pkg::CountW'(side_eff) * qpt_pkg::CountW'(side_eff);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q       <= qpt_pkg::op_e'(op_i);
      qubit_q[0] <= qubit_a_i;
      qubit_q[1] <= qubit_b_i;
      qubit_q[2] <= qubit_c_i;
      qubit_q[3] <= qubit_d_i;
      val_q      <= entry_value_i;
      side_q     <= side_eff;
      n_q        <= n_d;
    end
  end

  // range checks on operands and on cells read back
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      q_bad[k] = (qpt_pkg::CountW'(qubit_q[k]) >= n_q);
      p_bad[k] = (qpt_pkg::CountW'(phys_q[k]) >= n_q);
    end
    val_bad = (qpt_pkg::CountW'(val_q) >= n_q);

    unique case (op_q)
      qpt_pkg::OP_LOAD: begin
        idx_bad  = q_bad[0] || val_bad;
        phys_bad = 1'b0;
      end
      qpt_pkg::OP_SWAP: begin
        idx_bad  = q_bad[0] || q_bad[1];
        phys_bad = 1'b0;
      end
      qpt_pkg::OP_POS: begin
        idx_bad  = q_bad[0];
        phys_bad = p_bad[0];
      end
      qpt_pkg::OP_AREA: begin
        idx_bad  = q_bad[0] || q_bad[1];
        phys_bad = p_bad[0] || p_bad[1];
      end
      qpt_pkg::OP_OVERLAP: begin
        idx_bad  = q_bad[0] || q_bad[1] || q_bad[2] || q_bad[3];
        phys_bad = p_bad[0] || p_bad[1] || p_bad[2] || p_bad[3];
      end
      default: begin
        idx_bad  = 1'b0;
        phys_bad = 1'b0;
      end
    endcase
  end

  // placement memory: one write and one read port, identity fill after reset
  assign clr_last = (clr_cnt_q == AW'(Depth - 1));
  assign rd_addr  = AW'(qubit_q[cmd_i.rd_sel]);
  assign wr_addr  = AW'(qubit_q[cmd_i.wr_sel]);
  assign wr_data  = cmd_i.wr_from_phys ? phys_q[cmd_i.wr_phys_sel] : AW'(val_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_last ? '0 : clr_cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem[clr_cnt_q] <= clr_cnt_q;
    end else if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      phys_q[cmd_i.rd_sel] <= mem[rd_addr];
    end
  end

  // restoring divider, one quotient bit per cycle; cell < side^2 keeps the
  // quotient within QW bits
  assign rem_ge = (rem_q >= dsr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_init) begin
      dcnt_q <= CNTW'(QW - 1);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= RW'(phys_q[cmd_i.div_sel]);
      dsr_q <= RW'(side_q) << (QW - 1);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dsr_q;
      end
      quo_q <= QW'({quo_q, rem_ge});
      dsr_q <= dsr_q >> 1;
    end
    if (cmd_i.div_store) begin
      x_q[cmd_i.div_sel] <= rem_q[QW-1:0];
      y_q[cmd_i.div_sel] <= quo_q;
    end
  end

  // gate boxes as [lo, hi+1] in each axis
  always_comb begin
    lo_x1 = EW'(min2(x_q[0], x_q[1]));
    hi_x1 = EW'(max2(x_q[0], x_q[1])) + EW'(1);
    lo_y1 = EW'(min2(y_q[0], y_q[1]));
    hi_y1 = EW'(max2(y_q[0], y_q[1])) + EW'(1);
    lo_x2 = EW'(min2(x_q[2], x_q[3]));
    hi_x2 = EW'(max2(x_q[2], x_q[3])) + EW'(1);
    lo_y2 = EW'(min2(y_q[2], y_q[3]));
    hi_y2 = EW'(max2(y_q[2], y_q[3])) + EW'(1);

    dx   = hi_x1 - lo_x1;
    dy   = hi_y1 - lo_y1;
    prod = PW'(dx) * PW'(dy);
    area_d = (ACW'(prod) > ACW'(qpt_pkg::AreaMax)) ? qpt_pkg::AreaMax
                                                    : qpt_pkg::AreaW'(prod);
    // touching boxes count as overlapping
    ovl_d = (lo_x1 <= hi_x2) && (lo_x2 <= hi_x1) &&
            (lo_y1 <= hi_y2) && (lo_y2 <= hi_y1);
  end

  // only the field of the current op is nonzero, and none on an error
  always_comb begin
    cell_x_d   = '0;
    cell_y_d   = '0;
    box_area_d = '0;
    overlap_d  = 1'b0;
    if (!cmd_i.res_err) begin
      unique case (op_q)
        qpt_pkg::OP_POS: begin
          cell_x_d = qpt_pkg::CellW'(x_q[0]);
          cell_y_d = qpt_pkg::CellW'(y_q[0]);
        end
        qpt_pkg::OP_AREA:    box_area_d = area_d;
        qpt_pkg::OP_OVERLAP: overlap_d  = ovl_d;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      cell_x_o        <= cell_x_d;
      cell_y_o        <= cell_y_d;
      box_area_o      <= box_area_d;
      boxes_overlap_o <= overlap_d;
      index_error_o   <= cmd_i.res_err;
    end
  end

  assign status_o.op       = op_q;
  assign status_o.idx_bad  = idx_bad;
  assign status_o.phys_bad = phys_bad;
  assign status_o.clr_last = clr_last;
  assign status_o.div_last = (dcnt_q == '0);

endmodule

`default_nettype wire

// ===== rtl/qubit_placement_table.sv =====
// ----------------------------------------------------------------------------
// qubit_placement_table
// Logical-to-physical qubit placement table on a square grid.
// ----------------------------------------------------------------------------
// After reset the block fills its MAX_SIDE*MAX_SIDE entry table with the
// identity mapping, one entry per cycle, and holds in_stall_o high until
// that is done; side_length writes are taken at any time. One request is
// processed at a time: a new one is accepted only once the last one is in
// the result register. Each request passes the index check and then, as
// its op needs, reads its table entries, checks the cells read and divides
// each by the side, and writes the table; a failed check goes straight to
// the result. The table has one read and one write port, one read per cycle,
// and one shared divider yields one coordinate bit per cycle. A finished
// result sits in the output register while the next request is accepted.
`default_nettype none

module qubit_placement_table #(
  parameter int unsigned MAX_SIDE = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [qpt_pkg::SideW-1:0]    cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [2:0]                   op_i,
  input  wire logic [qpt_pkg::QubitW-1:0]   qubit_a_i,
  input  wire logic [qpt_pkg::QubitW-1:0]   qubit_b_i,
  input  wire logic [qpt_pkg::QubitW-1:0]   qubit_c_i,
  input  wire logic [qpt_pkg::QubitW-1:0]   qubit_d_i,
  input  wire logic [qpt_pkg::QubitW-1:0]   entry_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [qpt_pkg::CellW-1:0]         cell_x_o,
  output logic [qpt_pkg::CellW-1:0]         cell_y_o,
  output logic [qpt_pkg::AreaW-1:0]         box_area_o,
  output logic                              boxes_overlap_o,
  output logic                              index_error_o
);

  logic [qpt_pkg::SideW-1:0] side_length_q;
  qpt_pkg::cmd_t             cmd;
  qpt_pkg::status_t          status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_length_q <= qpt_pkg::SideReset;
    end else if (cfg_we_i) begin
      side_length_q <= cfg_wdata_i;
    end
  end

  qpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  qpt_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .side_length_i   (side_length_q),
    .op_i            (op_i),
    .qubit_a_i       (qubit_a_i),
    .qubit_b_i       (qubit_b_i),
    .qubit_c_i       (qubit_c_i),
    .qubit_d_i       (qubit_d_i),
    .entry_value_i   (entry_value_i),
    .cell_x_o        (cell_x_o),
    .cell_y_o        (cell_y_o),
    .box_area_o      (box_area_o),
    .boxes_overlap_o (boxes_overlap_o),
    .index_error_o   (index_error_o)
  );

endmodule

`default_nettype wire

// ===== rtl/qpt_checker.sv =====
// ----------------------------------------------------------------------------
// qpt_checker
// Port-level checks of the placement table, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qpt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_i,
  input wire logic        out_valid_i,
  input wire logic        out_stall_i,
  input wire logic [4:0]  cell_x_i,
  input wire logic [4:0]  cell_y_i,
  input wire logic [10:0] box_area_i,
  input wire logic        boxes_overlap_i,
  input wire logic        index_error_i
);

  `QPT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i, "result dropped while stalled")
  `QPT_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && out_stall_i |=> $stable({cell_x_i, cell_y_i, box_area_i, boxes_overlap_i, index_error_i}), "result changed while stalled")
  // one request in flight: an accept always closes the input for a while
  `QPT_ASSERT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_i |=> in_stall_i, "request accepted back to back")
  `QPT_ASSERT_NEVER(a_err_clean, clk_i, rst_ni, out_valid_i && index_error_i && (cell_x_i != 5'd0 || cell_y_i != 5'd0 || box_area_i != 11'd0 || boxes_overlap_i), "error result carries data")
  `QPT_ASSERT_NEVER(a_ovl_only, clk_i, rst_ni, out_valid_i && boxes_overlap_i && (cell_x_i != 5'd0 || cell_y_i != 5'd0 || box_area_i != 11'd0), "overlap result mixed with other fields")

endmodule

bind qubit_placement_table qpt_checker u_qpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_i      (in_stall_o),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .cell_x_i        (cell_x_o),
  .cell_y_i        (cell_y_o),
  .box_area_i      (box_area_o),
  .boxes_overlap_i (boxes_overlap_o),
  .index_error_i   (index_error_o)
);

`default_nettype wire

// ===== tb/sv/qubit_placement_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qubit_placement_table_tb
// Self-checking bench for the qubit placement table. Requests for every op
// are sent over the valid/stall channel and predicted by a scoreboard that
// keeps its own copy of the table and grid side. Each returned result is
// compared field by field. The side is changed between phases, and both
// channels idle in random bursts.
// ----------------------------------------------------------------------------

module qubit_placement_table_tb;

  localparam int unsigned MaxSide     = 32;
  localparam int unsigned TableDepth  = MaxSide * MaxSide;
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned PhaseItems  = 50;
  localparam logic [2:0]  OpFirstUnused = 3'd5;
  localparam logic [2:0]  OpLastUnused  = 3'd7;

  typedef struct {
    logic [qpt_pkg::CellW-1:0] cell_x;
    logic [qpt_pkg::CellW-1:0] cell_y;
    logic [qpt_pkg::AreaW-1:0] box_area;
    logic                      boxes_overlap;
    logic                      index_error;
  } placement_result_t;

  // Gate box as half-open intervals [x0, x1) and [y0, y1)
  typedef struct {
    int unsigned x0, x1, y0, y1;
  } box_t;

  class placement_scoreboard;
    logic [qpt_pkg::QubitW-1:0] phys_map [TableDepth];
    logic [qpt_pkg::SideW-1:0]  side_reg;
    placement_result_t          expected_results [$];
    int unsigned                fail_count;

    function new();
      for (int i = 0; i < TableDepth; i++) phys_map[i] = i[qpt_pkg::QubitW-1:0];
      side_reg   = qpt_pkg::SideReset;
      fail_count = 0;
    endfunction

    function void set_side(logic [qpt_pkg::SideW-1:0] v);
      side_reg = v;
    endfunction

    function int unsigned grid_side();
      if (side_reg == 0) return 1;
      if (side_reg > MaxSide) return MaxSide;
      return side_reg;
    endfunction

    function int unsigned cell_count();
      return grid_side() * grid_side();
    endfunction

    function int unsigned pending_count();
      return expected_results.size();
    endfunction

    // Also rejects stale entries left over from a larger side.
    function bit phys_of(int unsigned q, int unsigned n, output int unsigned p);
      p = 0;
      if (q >= n || q >= TableDepth) return 0;
      if (phys_map[q] >= n) return 0;
      p = phys_map[q];
      return 1;
    endfunction

    function bit gate_box(int unsigned c, int unsigned t, output box_t b);
      int unsigned pc, pt, xc, yc, xt, yt, side, n;
      side = grid_side();
      n    = side * side;
      b    = '{0, 0, 0, 0};
      if (!phys_of(c, n, pc) || !phys_of(t, n, pt)) return 0;
      xc = pc % side; yc = pc / side;
      xt = pt % side; yt = pt / side;
      b.x0 = (xc < xt) ? xc : xt;
      b.x1 = ((xc > xt) ? xc : xt) + 1;
      b.y0 = (yc < yt) ? yc : yt;
      b.y1 = ((yc > yt) ? yc : yt) + 1;
      return 1;
    endfunction

    function void note_request(logic [2:0] op,
                               logic [qpt_pkg::QubitW-1:0] qa, qb, qc, qd, val);
      placement_result_t          r;
      box_t                       b1, b2;
      int unsigned                side, n, p, area;
      logic [qpt_pkg::QubitW-1:0] held;
      side = grid_side();
      n    = side * side;
      r    = '{default: '0};
      case (op)
        qpt_pkg::OP_LOAD: begin
          if (qa >= n || val >= n) r.index_error = 1'b1;
          else phys_map[qa] = val;
        end
        qpt_pkg::OP_SWAP: begin
          if (qa >= n || qb >= n) begin
            r.index_error = 1'b1;
          end else begin
            held         = phys_map[qa];
            phys_map[qa] = phys_map[qb];
            phys_map[qb] = held;
          end
        end
        qpt_pkg::OP_POS: begin
          if (!phys_of(qa, n, p)) begin
            r.index_error = 1'b1;
          end else begin
            r.cell_x = qpt_pkg::CellW'(p % side);
            r.cell_y = qpt_pkg::CellW'(p / side);
          end
        end
        qpt_pkg::OP_AREA: begin
          if (!gate_box(qa, qb, b1)) begin
            r.index_error = 1'b1;
          end else begin
            area = (b1.x1 - b1.x0) * (b1.y1 - b1.y0);
            r.box_area = (area > qpt_pkg::AreaMax) ? qpt_pkg::AreaMax
                                                   : qpt_pkg::AreaW'(area);
          end
        end
        qpt_pkg::OP_OVERLAP: begin
          if (!gate_box(qa, qb, b1) || !gate_box(qc, qd, b2)) begin
            r.index_error = 1'b1;
          end else begin
            // closed comparison: touching boxes overlap
            r.boxes_overlap = (b1.x0 <= b2.x1) && (b2.x0 <= b1.x1) &&
                              (b1.y0 <= b2.y1) && (b2.y0 <= b1.y1);
          end
        end
        default: ;
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(placement_result_t got);
      placement_result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.cell_x !== exp_r.cell_x) begin
        $error("cell_x: expected %0d, actual %0d", exp_r.cell_x, got.cell_x);
        fail_count++;
      end
      if (got.cell_y !== exp_r.cell_y) begin
        $error("cell_y: expected %0d, actual %0d", exp_r.cell_y, got.cell_y);
        fail_count++;
      end
      if (got.box_area !== exp_r.box_area) begin
        $error("box_area: expected %0d, actual %0d", exp_r.box_area, got.box_area);
        fail_count++;
      end
      if (got.boxes_overlap !== exp_r.boxes_overlap) begin
        $error("boxes_overlap: expected %0d, actual %0d",
               exp_r.boxes_overlap, got.boxes_overlap);
        fail_count++;
      end
      if (got.index_error !== exp_r.index_error) begin
        $error("index_error: expected %0d, actual %0d",
               exp_r.index_error, got.index_error);
        fail_count++;
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [qpt_pkg::SideW-1:0]  cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [2:0]                 op_i;
  logic [qpt_pkg::QubitW-1:0] qubit_a_i, qubit_b_i, qubit_c_i, qubit_d_i, entry_value_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [qpt_pkg::CellW-1:0]  cell_x_o, cell_y_o;
  logic [qpt_pkg::AreaW-1:0]  box_area_o;
  logic                       boxes_overlap_o;
  logic                       index_error_o;

  placement_scoreboard sb = new();
  bit                  idle_enable = 1'b1;
  int unsigned         cycle_count = 0;
  int unsigned         out_stall_left = 0;

  qubit_placement_table #(.MAX_SIDE(MaxSide)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .qubit_a_i      (qubit_a_i),
    .qubit_b_i      (qubit_b_i),
    .qubit_c_i      (qubit_c_i),
    .qubit_d_i      (qubit_d_i),
    .entry_value_i  (entry_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_x_o       (cell_x_o),
    .cell_y_o       (cell_y_o),
    .box_area_o     (box_area_o),
    .boxes_overlap_o(boxes_overlap_o),
    .index_error_o  (index_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[qubit_placement_table] ERROR");
      $finish;
    end
  end

  // Result side: random stall bursts
  always @(negedge clk_i) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_stall_i = 1'b1;
    end else if (idle_enable && $urandom_range(0, 99) < 12) begin
      out_stall_left = $urandom_range(1, 15) - 1;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    placement_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.cell_x        = cell_x_o;
      got.cell_y        = cell_y_o;
      got.box_area      = box_area_o;
      got.boxes_overlap = boxes_overlap_o;
      got.index_error   = index_error_o;
      sb.check_result(got);
    end
  end

  // Leaves in_valid_i high after the accept so back-to-back requests stay up.
  task automatic send_request(logic [2:0] op,
                              logic [qpt_pkg::QubitW-1:0] qa, qb, qc, qd, val);
    @(negedge clk_i);
    if (idle_enable && $urandom_range(0, 99) < 25) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    op_i          = op;
    qubit_a_i     = qa;
    qubit_b_i     = qb;
    qubit_c_i     = qc;
    qubit_d_i     = qd;
    entry_value_i = val;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, qa, qb, qc, qd, val);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Only written with no request in flight.
  task automatic write_side(logic [qpt_pkg::SideW-1:0] v);
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(posedge clk_i);
    sb.set_side(v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly in range so that requests get past the index checks.
  function automatic logic [qpt_pkg::QubitW-1:0] pick_index(int unsigned n);
    if ($urandom_range(0, 9) < 9) return qpt_pkg::QubitW'($urandom_range(0, n - 1));
    return qpt_pkg::QubitW'($urandom_range(0, TableDepth - 1));
  endfunction

  task automatic send_random();
    int unsigned       n, r;
    logic [2:0]        op;
    n = sb.cell_count();
    r = $urandom_range(0, 99);
    if      (r < 20) op = qpt_pkg::OP_LOAD;
    else if (r < 35) op = qpt_pkg::OP_SWAP;
    else if (r < 55) op = qpt_pkg::OP_POS;
    else if (r < 75) op = qpt_pkg::OP_AREA;
    else if (r < 95) op = qpt_pkg::OP_OVERLAP;
    else             op = 3'($urandom_range(OpFirstUnused, OpLastUnused));
    send_request(op, pick_index(n), pick_index(n), pick_index(n), pick_index(n),
                 pick_index(n));
  endtask

  initial begin
    logic [qpt_pkg::SideW-1:0] phase_sides [12];
    phase_sides = '{6'd32, 6'd5, 6'd1, 6'd0, 6'd16, 6'd33,
                    6'd7, 6'd2, 6'd63, 6'd31, 6'd3, 6'd32};

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    out_stall_i   = 1'b0;
    op_i          = qpt_pkg::OP_LOAD;
    qubit_a_i     = '0;
    qubit_b_i     = '0;
    qubit_c_i     = '0;
    qubit_d_i     = '0;
    entry_value_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: full grid corners, touching boxes, end loads, swaps, unused ops
    write_side(6'd32);
    send_request(qpt_pkg::OP_POS,     10'd0,    10'd0,    10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_POS,     10'd1023, 10'd0,    10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_AREA,    10'd0,    10'd1023, 10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_AREA,    10'd5,    10'd5,    10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_OVERLAP, 10'd0,    10'd33,   10'd66,   10'd99,   10'd0);
    send_request(qpt_pkg::OP_OVERLAP, 10'd0,    10'd0,    10'd1023, 10'd1023, 10'd0);
    send_request(qpt_pkg::OP_OVERLAP, 10'd0,    10'd32,   10'd1,    10'd33,   10'd0);
    send_request(qpt_pkg::OP_LOAD,    10'd1023, 10'd0,    10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_LOAD,    10'd0,    10'd0,    10'd0,    10'd0,    10'd1023);
    send_request(qpt_pkg::OP_POS,     10'd0,    10'd0,    10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_SWAP,    10'd0,    10'd1023, 10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_POS,     10'd1023, 10'd0,    10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_SWAP,    10'd0,    10'd0,    10'd0,    10'd0,    10'd0);
    for (int u = OpFirstUnused; u <= OpLastUnused; u++)
      send_request(3'(u), 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    drop_valid();

    // Bad and valid indices and values on a 4x4 grid
    write_side(6'd4);
    send_request(qpt_pkg::OP_LOAD,    10'd16,   10'd0,    10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_LOAD,    10'd2,    10'd0,    10'd0,    10'd0,    10'd16);
    send_request(qpt_pkg::OP_LOAD,    10'd2,    10'd0,    10'd0,    10'd0,    10'd15);
    send_request(qpt_pkg::OP_SWAP,    10'd3,    10'd16,   10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_POS,     10'd1023, 10'd0,    10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_AREA,    10'd0,    10'd15,   10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_OVERLAP, 10'd0,    10'd1,    10'd2,    10'd20,   10'd0);
    drop_valid();

    // Entry 2 now points past a 2x2 grid: stale lookup
    write_side(6'd2);
    send_request(qpt_pkg::OP_POS,     10'd2,    10'd0,    10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_AREA,    10'd2,    10'd0,    10'd0,    10'd0,    10'd0);
    send_request(qpt_pkg::OP_LOAD,    10'd2,    10'd0,    10'd0,    10'd0,    10'd3);
    drop_valid();

    foreach (phase_sides[i]) begin
      write_side(phase_sides[i]);
      if (i == $size(phase_sides) - 1) idle_enable = 1'b0;
      repeat (PhaseItems) send_random();
      drop_valid();
    end

    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending_count() == 0) begin
      $display("[qubit_placement_table] OK");
    end else begin
      $display("[qubit_placement_table] ERROR");
    end
    $finish;
  end

endmodule
